@@ src/median_filter_3x3_defines.svh @@
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

// Both macros sample on clk and are switched off while rst is high.
`define MF3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mf3_pkg.sv @@
package mf3_pkg;

  localparam int PIX_W = 24;
  localparam int LINE_WIDTH_W = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_LINE_WIDTH = 1024;
  localparam int DEF_MAX_FRAME_HEIGHT = 4096;
  localparam int RESET_LINE_WIDTH = 640;
  localparam int RESET_FRAME_HEIGHT = 480;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH,
    REG_FRAME_HEIGHT
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL,
    KIND_PAD
  } kind_t;

  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
  } trio_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic trio_t sort3(pix_t a, pix_t b, pix_t c);
    trio_t t;
    t.lo = min2(min2(a, b), c);
    t.md = med3(a, b, c);
    t.hi = max2(max2(a, b), c);
    return t;
  endfunction

endpackage

@@ src/mf3_in_if.sv @@
interface mf3_in_if;
  logic valid;
  logic ready;
  logic kind;
  mf3_pkg::pix_t pixel_rgb;

  modport source (output valid, output kind, output pixel_rgb, input ready);
  modport sink (input valid, input kind, input pixel_rgb, output ready);
endinterface

@@ src/mf3_out_if.sv @@
interface mf3_out_if;
  logic valid;
  logic ready;
  mf3_pkg::pix_t median_rgb;
  logic frame_end;

  modport source (output valid, output median_rgb, output frame_end, input ready);
  modport sink (input valid, input median_rgb, input frame_end, output ready);
endinterface

@@ src/median_filter_3x3.sv @@
// 3x3 median filter for a raster stream of packed RGB pixels.
// Words enter on the pixels channel: kind 0 carries a pixel, kind 1 is a
// pad that flushes the tail of a frame. Pads are dropped while pixels of the
// frame are still due. After the last pixel, line_width + 1 further words of
// either kind drain the frame; the median for pixel q is caused by input
// word q + line_width + 1, and frame_end marks the last median of a frame.
// Medians leave on the medians channel after the causing word passes s1 to
// s4 and the output register. One word per clock is taken while the receiver
// does not stall; each line store has one read and one write port. The user
// must write line width and frame height via cfg_write, cfg_index and cfg_data
// only while the block is idle, which it does not enforce; a write restarts the
// frame position. Reset sets the registers to 640 by 480, clears the counters
// and the window, and leaves the line stores as they are; no clearing pass is run.
// When the receiver stalls, the output register holds its word and the four
// pipeline stages fill one by one before pixels.ready drops.
module median_filter_3x3 #(
  parameter int MAX_LINE_WIDTH = mf3_pkg::DEF_MAX_LINE_WIDTH,
  parameter int MAX_FRAME_HEIGHT = mf3_pkg::DEF_MAX_FRAME_HEIGHT
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data,
  mf3_in_if.sink pixels,
  mf3_out_if.source medians
);

  `include "median_filter_3x3_defines.svh"

  localparam int LW_W = $clog2(MAX_LINE_WIDTH + 1);
  localparam int FH_W = $clog2(MAX_FRAME_HEIGHT + 1);
  localparam int XW = $clog2(MAX_LINE_WIDTH);
  localparam int CW = XW + 1;
  localparam int YW = $clog2(MAX_FRAME_HEIGHT + 2);
  localparam int RST_LW = (mf3_pkg::RESET_LINE_WIDTH > MAX_LINE_WIDTH) ?
                          MAX_LINE_WIDTH : mf3_pkg::RESET_LINE_WIDTH;
  localparam int RST_FH = (mf3_pkg::RESET_FRAME_HEIGHT > MAX_FRAME_HEIGHT) ?
                          MAX_FRAME_HEIGHT : mf3_pkg::RESET_FRAME_HEIGHT;

  logic [LW_W-1:0] line_width;
  logic [FH_W-1:0] frame_height;
  logic [LW_W-1:0] line_width_next;
  logic [FH_W-1:0] frame_height_next;
  logic [mf3_pkg::LINE_WIDTH_W-1:0] cfg_lw_raw;
  logic [mf3_pkg::FRAME_HEIGHT_W-1:0] cfg_fh_raw;

  assign cfg_lw_raw = cfg_data[mf3_pkg::LINE_WIDTH_W-1:0];
  assign cfg_fh_raw = cfg_data[mf3_pkg::FRAME_HEIGHT_W-1:0];

  always_comb begin
    if (cfg_lw_raw == '0) begin
      line_width_next = LW_W'(1);
    end else if (32'(cfg_lw_raw) > MAX_LINE_WIDTH) begin
      line_width_next = LW_W'(MAX_LINE_WIDTH);
    end else begin
      line_width_next = LW_W'(cfg_lw_raw);
    end
    if (cfg_fh_raw == '0) begin
      frame_height_next = FH_W'(1);
    end else if (32'(cfg_fh_raw) > MAX_FRAME_HEIGHT) begin
      frame_height_next = FH_W'(MAX_FRAME_HEIGHT);
    end else begin
      frame_height_next = FH_W'(cfg_fh_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LW_W'(RST_LW);
      frame_height <= FH_W'(RST_FH);
    end else if (cfg_write) begin
      unique case (cfg_index)
        mf3_pkg::REG_LINE_WIDTH: line_width <= line_width_next;
        mf3_pkg::REG_FRAME_HEIGHT: frame_height <= frame_height_next;
      endcase
    end
  end

  logic s1_valid, s2_valid, s3_valid, s4_valid, out_valid;
  logic s1_free, s2_free, s3_free, s4_free, out_free;
  logic s1_fire;

  assign out_free = !out_valid || medians.ready;
  assign s4_free = !s4_valid || out_free;
  assign s3_free = !s3_valid || s4_free;
  assign s2_free = !s2_valid || s3_free;
  assign s1_free = !s1_valid || s2_free;
  assign s1_fire = s1_valid && s2_free;
  assign pixels.ready = s1_free;

  logic [XW-1:0] column_count;
  logic [YW-1:0] row_count;
  logic [YW-1:0] fh_plus1;
  logic in_fire, in_frame, take, acc_emit, acc_last, col_at_end;

  assign fh_plus1 = YW'(frame_height) + YW'(1);
  assign in_fire = pixels.valid && pixels.ready;
  assign in_frame = row_count < YW'(frame_height);
  assign take = in_fire && !(in_frame && pixels.kind == mf3_pkg::KIND_PAD);
  assign acc_emit = (row_count >= YW'(2)) || (row_count == YW'(1) && column_count != '0);
  assign acc_last = acc_emit && row_count == fh_plus1 && column_count == '0;
  assign col_at_end = (CW'(column_count) + CW'(1)) == CW'(line_width);

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      column_count <= '0;
      row_count <= '0;
    end else if (take) begin
      if (acc_last) begin
        column_count <= '0;
        row_count <= '0;
      end else if (col_at_end) begin
        column_count <= '0;
        row_count <= row_count + YW'(1);
      end else begin
        column_count <= column_count + XW'(1);
      end
    end
  end

  logic [XW-1:0] s1_x;
  mf3_pkg::pix_t s1_v, s1_top, s1_mid, rd_upper, rd_lower;
  logic s1_top_en, s1_mid_en, s1_x0, s1_emit, s1_last;
  logic fwd;

  assign fwd = take && s1_fire && (column_count == s1_x);
  assign s1_top = s1_top_en ? rd_upper : '0;
  assign s1_mid = s1_mid_en ? rd_lower : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_x <= column_count;
      s1_v <= in_frame ? pixels.pixel_rgb : '0;
      s1_top_en <= row_count >= YW'(2);
      s1_mid_en <= row_count >= YW'(1);
      s1_x0 <= column_count == '0;
      s1_emit <= acc_emit;
      s1_last <= acc_last;
    end
  end

  mf3_pkg::pix_t store_upper [MAX_LINE_WIDTH];
  mf3_pkg::pix_t store_lower [MAX_LINE_WIDTH];

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      store_upper[s1_x] <= s1_mid;
      store_lower[s1_x] <= s1_v;
    end
    if (take) begin
      rd_upper <= fwd ? s1_mid : store_upper[column_count];
      rd_lower <= fwd ? s1_v : store_lower[column_count];
    end
  end

  mf3_pkg::pix_t win [9];
  mf3_pkg::pix_t win_next [9];
  mf3_pkg::pix_t med_in [9];
  mf3_pkg::pix_t col_in [3];

  always_comb begin
    col_in[0] = s1_x0 ? '0 : s1_top;
    col_in[1] = s1_x0 ? '0 : s1_mid;
    col_in[2] = s1_x0 ? '0 : s1_v;
    for (int r = 0; r < 3; r++) begin
      med_in[r*3] = win[r*3+1];
      med_in[r*3+1] = win[r*3+2];
      med_in[r*3+2] = col_in[r];
    end
    for (int i = 0; i < 9; i++) begin
      win_next[i] = (s1_x0 || s1_last) ? '0 : med_in[i];
    end
    if (s1_x0 && !s1_last) begin
      win_next[2] = s1_top;
      win_next[5] = s1_mid;
      win_next[8] = s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (s1_fire) begin
      win <= win_next;
    end
  end

  mf3_pkg::pix_t s2_win [9];
  mf3_pkg::trio_t s3_rows [3];
  mf3_pkg::pix_t s4_lo, s4_md, s4_hi, out_median;
  logic s2_last, s3_last, s4_last, out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid <= s1_fire && s1_emit;
      end
      if (s3_free) begin
        s3_valid <= s2_valid;
      end
      if (s4_free) begin
        s4_valid <= s3_valid;
      end
      if (out_free) begin
        out_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_win <= med_in;
      s2_last <= s1_last;
    end
    if (s3_free) begin
      for (int r = 0; r < 3; r++) begin
        s3_rows[r] <= mf3_pkg::sort3(s2_win[r*3], s2_win[r*3+1], s2_win[r*3+2]);
      end
      s3_last <= s2_last;
    end
    if (s4_free) begin
      s4_lo <= mf3_pkg::max2(mf3_pkg::max2(s3_rows[0].lo, s3_rows[1].lo), s3_rows[2].lo);
      s4_md <= mf3_pkg::med3(s3_rows[0].md, s3_rows[1].md, s3_rows[2].md);
      s4_hi <= mf3_pkg::min2(mf3_pkg::min2(s3_rows[0].hi, s3_rows[1].hi), s3_rows[2].hi);
      s4_last <= s3_last;
    end
    if (out_free) begin
      out_median <= mf3_pkg::med3(s4_lo, s4_md, s4_hi);
      out_last <= s4_last;
    end
  end

  assign medians.valid = out_valid;
  assign medians.median_rgb = out_median;
  assign medians.frame_end = out_last;

  `MF3_ASSERT_IMP(a_col_range, 1'b1, CW'(column_count) < CW'(line_width),
                  "column count reached the line width")
  `MF3_ASSERT_IMP(a_row_range, 1'b1, row_count <= fh_plus1,
                  "row count ran past the flush rows")
  `MF3_ASSERT_IMP(a_fwd_width, fwd && row_count != '0, line_width == LW_W'(1),
                  "line store bypass used with a line wider than one pixel")
  `MF3_ASSERT_NEXT(a_last_restart, take && acc_last,
                   row_count == '0 && column_count == '0,
                   "frame position not cleared after the last word of a frame")

endmodule
